// ===== design/swd_pkg.sv =====
package swd_pkg;

   // line reset timing and sequences
   localparam int          LINE_RESET_CYCLES = 51;
   localparam int          CNT_W             = 7;
   localparam logic [15:0] SWITCH_SEQ        = 16'hE79E;
   localparam logic [7:0]  MAX_RETRIES_RESET = 8'd64;

   // request codes on the input channel
   localparam logic [1:0] REQ_TICK       = 2'd0;
   localparam logic [1:0] REQ_XFER       = 2'd1;
   localparam logic [1:0] REQ_LINE_RESET = 2'd2;

   // acknowledge codes, first received bit in bit 0
   localparam logic [2:0] ACK_OK    = 3'b001;
   localparam logic [2:0] ACK_WAIT  = 3'b010;
   localparam logic [2:0] ACK_FAULT = 3'b100;

   // register file
   localparam int         CSR_ADDR_W      = 3;
   localparam logic [0:0] CSR_MAX_RETRIES = 1'b0;

   typedef enum logic [2:0] {
      ST_OK,
      ST_FAULT,
      ST_BAD_ACK,
      ST_PARITY,
      ST_TIMEOUT
   } status_type;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_LR1,
      PH_SWITCH,
      PH_LR2,
      PH_LRIDLE,
      PH_REQ,
      PH_TRN1,
      PH_ACK,
      PH_RDATA,
      PH_RPAR,
      PH_TRNB,
      PH_TRNW,
      PH_WDATA,
      PH_WPAR,
      PH_TRNF
   } phase_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic        ap_not_dp;
      logic        read_not_write;
      logic [1:0]  reg_addr;
      logic [31:0] write_data;
      logic        swdio_in;
   } req_type;

   typedef struct packed {
      logic        clock_active;
      logic        swdio_out;
      logic        swdio_drive;
      logic        busy_res;
      logic        done_res;
      logic [2:0]  status;
      logic [31:0] read_data;
   } rsp_type;

   // request header: start, APnDP, RnW, A2, A3, even parity, stop, park
   function automatic logic [7:0] request_byte(input logic [3:0] cmd);
      logic par;
      par = ^cmd;
      return {1'b1, 1'b0, par, cmd[3], cmd[2], cmd[1], cmd[0], 1'b1};
   endfunction

endpackage

// ===== design/swd_host_transaction_engine_top.sv =====
// Serial Wire Debug host engine. Each transfer on the req channel is one SWCLK
// cycle: it carries the sampled SWDIO level and, while the engine is idle, an
// optional command (line reset or DP/AP read/write). Each accepted transfer
// yields exactly one rsp transfer with the pin levels and status of that cycle.
// One transfer is accepted per clock cycle unless rsp_stall holds a full result
// register; each request passes the input register, then the phase/counter
// update into the result register. The retry limit lives at APB byte address 0.
module swd_host_transaction_engine_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  swd_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output swd_pkg::rsp_type              rsp_data,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [swd_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);
   import swd_pkg::*;

   logic       req_valid_ff, req_valid_in;
   req_type    req_ff, req_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;
   rsp_type    core_rsp;
   logic       advance;
   logic       accept;
   logic [7:0] max_retries;

   // handshake: input register feeds the result register when it has room
   assign advance   = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      req_valid_in = req_valid_ff;
      req_in       = req_ff;
      if (accept) begin
         req_valid_in = 1'b1;
         req_in       = req_data;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_in       = core_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   swd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .max_retries (max_retries)
   );

   swd_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .req         (req_ff),
      .max_retries (max_retries),
      .rsp         (core_rsp)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== design/swd_csr.sv =====
module swd_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [swd_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready,
   output logic [7:0]                    max_retries
);
   import swd_pkg::*;

   logic [7:0] max_retries_ff;
   logic [7:0] max_retries_in;
   logic       wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && (paddr[2] == CSR_MAX_RETRIES);

   // retry limit register
   always_comb begin
      max_retries_in = max_retries_ff;
      if (wr_en) begin
         max_retries_in = pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_retries_ff <= MAX_RETRIES_RESET;
      end else begin
         max_retries_ff <= max_retries_in;
      end
   end

   // read back
   always_comb begin
      prdata = 32'd0;
      if (paddr[2] == CSR_MAX_RETRIES) begin
         prdata = {24'd0, max_retries_ff};
      end
   end

   assign max_retries = max_retries_ff;

endmodule

// ===== design/swd_core.sv =====
module swd_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  swd_pkg::req_type req,
   input  logic [7:0]       max_retries,
   output swd_pkg::rsp_type rsp
);
   import swd_pkg::*;

   phase_type        phase_ff, phase_in, eff_phase;
   logic [CNT_W-1:0] bc_ff, bc_in, eff_bc, bc_inc;
   logic [31:0]      data_ff, data_in;
   logic [2:0]       ack_ff, ack_in, ack_new;
   logic [7:0]       retry_ff, retry_in, eff_retry, retry_inc;
   logic             line_ff, line_in;
   logic [3:0]       cmd_ff, cmd_in, eff_cmd;
   logic [31:0]      word_ff, word_in, eff_word;
   logic             par_ff, par_in;
   logic             level_ff, level_in;
   logic [7:0]       req_byte;

   logic             clk_o, drv_o, dout_o, done_o;
   status_type       st_o;
   logic [31:0]      rd_o;

   // command start on an idle cycle
   always_comb begin
      eff_phase = phase_ff;
      eff_bc    = bc_ff;
      eff_cmd   = cmd_ff;
      eff_word  = word_ff;
      eff_retry = retry_ff;
      if (phase_ff == PH_IDLE) begin
         if (req.req_type == REQ_XFER) begin
            eff_cmd   = {req.reg_addr, req.read_not_write, req.ap_not_dp};
            eff_word  = req.write_data;
            eff_retry = 8'd0;
            eff_bc    = '0;
            eff_phase = PH_REQ;
         end else if (req.req_type == REQ_LINE_RESET) begin
            eff_bc    = '0;
            eff_phase = PH_LR1;
         end
      end
   end

   assign bc_inc    = eff_bc + CNT_W'(1);
   assign retry_inc = eff_retry + 8'd1;
   assign ack_new   = ack_ff | ({2'b00, req.swdio_in} << eff_bc[1:0]);
   assign req_byte  = request_byte(eff_cmd);

   // next state
   always_comb begin
      phase_in = eff_phase;
      bc_in    = eff_bc;
      cmd_in   = eff_cmd;
      word_in  = eff_word;
      retry_in = eff_retry;
      data_in  = data_ff;
      ack_in   = ack_ff;
      par_in   = par_ff;
      case (eff_phase)
         PH_LR1, PH_LR2: begin
            bc_in = bc_inc;
            if (bc_inc >= CNT_W'(LINE_RESET_CYCLES)) begin
               bc_in    = '0;
               phase_in = (eff_phase == PH_LR1) ? PH_SWITCH : PH_LRIDLE;
            end
         end
         PH_SWITCH: begin
            bc_in = bc_inc;
            if (bc_inc >= CNT_W'(16)) begin
               bc_in    = '0;
               phase_in = PH_LR2;
            end
         end
         PH_LRIDLE: begin
            bc_in = bc_inc;
            if (bc_inc >= CNT_W'(2)) begin
               bc_in    = '0;
               phase_in = PH_IDLE;
            end
         end
         PH_REQ: begin
            bc_in = bc_inc;
            if (bc_inc >= CNT_W'(8)) begin
               bc_in    = '0;
               phase_in = PH_TRN1;
            end
         end
         PH_TRN1: begin
            ack_in   = 3'd0;
            bc_in    = '0;
            phase_in = PH_ACK;
         end
         PH_ACK: begin
            ack_in = ack_new;
            bc_in  = bc_inc;
            if (bc_inc >= CNT_W'(3)) begin
               bc_in = '0;
               if (ack_new == ACK_OK) begin
                  if (eff_cmd[1]) begin
                     data_in  = 32'd0;
                     par_in   = 1'b0;
                     phase_in = PH_RDATA;
                  end else begin
                     phase_in = PH_TRNW;
                  end
               end else begin
                  phase_in = PH_TRNF;
               end
            end
         end
         PH_RDATA: begin
            data_in = data_ff | ({31'd0, req.swdio_in} << eff_bc[4:0]);
            par_in  = par_ff ^ req.swdio_in;
            bc_in   = bc_inc;
            if (bc_inc >= CNT_W'(32)) begin
               bc_in    = '0;
               phase_in = PH_RPAR;
            end
         end
         PH_RPAR: begin
            par_in   = par_ff ^ req.swdio_in;
            phase_in = PH_TRNB;
         end
         PH_TRNB: begin
            phase_in = PH_IDLE;
         end
         PH_TRNW: begin
            bc_in    = '0;
            phase_in = PH_WDATA;
         end
         PH_WDATA: begin
            bc_in = bc_inc;
            if (bc_inc >= CNT_W'(32)) begin
               bc_in    = '0;
               phase_in = PH_WPAR;
            end
         end
         PH_WPAR: begin
            phase_in = PH_IDLE;
         end
         PH_TRNF: begin
            if (ack_ff == ACK_WAIT) begin
               retry_in = retry_inc;
               if (retry_inc >= max_retries) begin
                  phase_in = PH_IDLE;
               end else begin
                  bc_in    = '0;
                  phase_in = PH_REQ;
               end
            end else begin
               phase_in = PH_IDLE;
            end
         end
         PH_IDLE: begin
         end
         default: begin
            phase_in = PH_IDLE;
            bc_in    = '0;
         end
      endcase
   end

   // pin outputs and status for this cycle
   always_comb begin
      clk_o  = 1'b0;
      drv_o  = 1'b0;
      dout_o = 1'b0;
      done_o = 1'b0;
      st_o   = ST_OK;
      rd_o   = 32'd0;
      case (eff_phase)
         PH_LR1, PH_LR2: begin
            clk_o  = 1'b1;
            drv_o  = 1'b1;
            dout_o = 1'b1;
         end
         PH_SWITCH: begin
            clk_o  = 1'b1;
            drv_o  = 1'b1;
            dout_o = SWITCH_SEQ[eff_bc[3:0]];
         end
         PH_LRIDLE: begin
            clk_o  = 1'b1;
            drv_o  = 1'b1;
            done_o = (bc_inc >= CNT_W'(2));
         end
         PH_REQ: begin
            clk_o  = 1'b1;
            drv_o  = 1'b1;
            dout_o = req_byte[eff_bc[2:0]];
         end
         PH_TRN1, PH_ACK, PH_RDATA, PH_RPAR: begin
            clk_o = 1'b1;
         end
         PH_TRNB: begin
            clk_o  = 1'b1;
            drv_o  = 1'b1;
            done_o = 1'b1;
            st_o   = par_ff ? ST_PARITY : ST_OK;
            rd_o   = data_ff;
         end
         PH_TRNW: begin
            clk_o = 1'b1;
            drv_o = 1'b1;
         end
         PH_WDATA: begin
            clk_o  = 1'b1;
            drv_o  = 1'b1;
            dout_o = eff_word[eff_bc[4:0]];
         end
         PH_WPAR: begin
            clk_o  = 1'b1;
            drv_o  = 1'b1;
            dout_o = ^eff_word;
            done_o = 1'b1;
         end
         PH_TRNF: begin
            clk_o = 1'b1;
            if (ack_ff == ACK_WAIT) begin
               if (retry_inc >= max_retries) begin
                  done_o = 1'b1;
                  st_o   = ST_TIMEOUT;
               end
            end else begin
               done_o = 1'b1;
               st_o   = (ack_ff == ACK_FAULT) ? ST_FAULT : ST_BAD_ACK;
            end
         end
         default: begin
            drv_o  = line_ff;
            dout_o = line_ff & level_ff;
         end
      endcase
   end

   // line hold state: released on a failed acknowledge, low after a finish
   always_comb begin
      line_in  = clk_o ? drv_o : line_ff;
      level_in = (clk_o && drv_o) ? dout_o : level_ff;
      if (done_o && line_in) begin
         level_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         bc_ff    <= '0;
         data_ff  <= 32'd0;
         ack_ff   <= 3'd0;
         retry_ff <= 8'd0;
         line_ff  <= 1'b0;
         cmd_ff   <= 4'd0;
         word_ff  <= 32'd0;
         par_ff   <= 1'b0;
         level_ff <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         bc_ff    <= bc_in;
         data_ff  <= data_in;
         ack_ff   <= ack_in;
         retry_ff <= retry_in;
         line_ff  <= line_in;
         cmd_ff   <= cmd_in;
         word_ff  <= word_in;
         par_ff   <= par_in;
         level_ff <= level_in;
      end
   end

   always_comb begin
      rsp.clock_active = clk_o;
      rsp.swdio_out    = dout_o;
      rsp.swdio_drive  = drv_o;
      rsp.busy_res     = (phase_in != PH_IDLE);
      rsp.done_res     = done_o;
      rsp.status       = st_o;
      rsp.read_data    = rd_o;
   end

endmodule

// ===== sim/swd_host_transaction_engine_top_tb.sv =====
`timescale 1ns / 100ps

module swd_host_transaction_engine_top_tb;
   import swd_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam logic [CSR_ADDR_W-1:0] RETRY_ADDR = {CSR_MAX_RETRIES, 2'b00};
   localparam logic [1:0] REQ_SPARE = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   swd_host_transaction_engine_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #5 clock = ~clock;

   // engine image used to predict each cycle
   phase_type   eng_phase = PH_IDLE;
   logic [6:0]  bit_cnt = '0;
   logic [31:0] rx_word = '0;
   logic [2:0]  rx_ack = '0;
   logic [7:0]  retry_cnt = '0;
   logic        line_drv = 1'b0;
   logic [3:0]  cmd_held = '0;
   logic [31:0] wr_word = '0;
   logic        rx_par = 1'b0;
   logic        line_level = 1'b0;
   logic [7:0]  retry_limit = MAX_RETRIES_RESET;

   // what the simulated target answers
   logic [2:0]  ack_plan[$];
   logic [2:0]  cur_ack = ACK_OK;
   logic [31:0] rd_plan = '0;
   logic        rd_bad_par = 1'b0;

   rsp_type     expected_cycles[$];
   int          errors = 0;
   int          n_items = 0;
   int          cycles = 0;
   logic        idle_on = 1'b1;
   int          stall_left = 0;
   int          busy_cmd_rate = 8;

   // one swclk cycle of the engine
   function automatic rsp_type engine_cycle(input req_type it);
      rsp_type    r;
      logic       clk, drv, dout, done;
      status_type st;
      logic [31:0] rd;
      clk = 1'b0; drv = 1'b0; dout = 1'b0; done = 1'b0; st = ST_OK; rd = '0;
      if (eng_phase == PH_IDLE) begin
         if (it.req_type == REQ_XFER) begin
            cmd_held  = {it.reg_addr, it.read_not_write, it.ap_not_dp};
            wr_word   = it.write_data;
            retry_cnt = '0;
            bit_cnt   = '0;
            eng_phase = PH_REQ;
         end else if (it.req_type == REQ_LINE_RESET) begin
            bit_cnt   = '0;
            eng_phase = PH_LR1;
         end
      end
      case (eng_phase)
         PH_LR1, PH_LR2: begin
            clk = 1'b1; drv = 1'b1; dout = 1'b1;
            bit_cnt = bit_cnt + 7'd1;
            if (bit_cnt >= LINE_RESET_CYCLES) begin
               bit_cnt = '0;
               if (eng_phase == PH_LR1) eng_phase = PH_SWITCH;
               else eng_phase = PH_LRIDLE;
            end
         end
         PH_SWITCH: begin
            clk = 1'b1; drv = 1'b1;
            dout = SWITCH_SEQ[bit_cnt[3:0]];
            bit_cnt = bit_cnt + 7'd1;
            if (bit_cnt >= 16) begin bit_cnt = '0; eng_phase = PH_LR2; end
         end
         PH_LRIDLE: begin
            clk = 1'b1; drv = 1'b1; dout = 1'b0;
            bit_cnt = bit_cnt + 7'd1;
            if (bit_cnt >= 2) begin bit_cnt = '0; eng_phase = PH_IDLE; done = 1'b1; end
         end
         PH_REQ: begin
            clk = 1'b1; drv = 1'b1;
            // start, apndp, rnw, a2, a3, parity, stop, park
            case (bit_cnt[2:0])
               3'd0: dout = 1'b1;
               3'd1: dout = cmd_held[0];
               3'd2: dout = cmd_held[1];
               3'd3: dout = cmd_held[2];
               3'd4: dout = cmd_held[3];
               3'd5: dout = cmd_held[0] ^ cmd_held[1] ^ cmd_held[2] ^ cmd_held[3];
               3'd6: dout = 1'b0;
               default: dout = 1'b1;
            endcase
            bit_cnt = bit_cnt + 7'd1;
            if (bit_cnt >= 8) begin bit_cnt = '0; eng_phase = PH_TRN1; end
         end
         PH_TRN1: begin
            clk = 1'b1;
            rx_ack = '0; bit_cnt = '0; eng_phase = PH_ACK;
         end
         PH_ACK: begin
            clk = 1'b1;
            rx_ack = rx_ack | ({2'b00, it.swdio_in} << bit_cnt[1:0]);
            bit_cnt = bit_cnt + 7'd1;
            if (bit_cnt >= 3) begin
               bit_cnt = '0;
               if (rx_ack == ACK_OK) begin
                  if (cmd_held[1]) begin
                     rx_word = '0; rx_par = 1'b0; eng_phase = PH_RDATA;
                  end else begin
                     eng_phase = PH_TRNW;
                  end
               end else begin
                  eng_phase = PH_TRNF;
               end
            end
         end
         PH_RDATA: begin
            clk = 1'b1;
            rx_word = rx_word | ({31'b0, it.swdio_in} << bit_cnt[4:0]);
            rx_par = rx_par ^ it.swdio_in;
            bit_cnt = bit_cnt + 7'd1;
            if (bit_cnt >= 32) begin bit_cnt = '0; eng_phase = PH_RPAR; end
         end
         PH_RPAR: begin
            clk = 1'b1;
            rx_par = rx_par ^ it.swdio_in;
            eng_phase = PH_TRNB;
         end
         PH_TRNB: begin
            clk = 1'b1; drv = 1'b1; dout = 1'b0;
            done = 1'b1; rd = rx_word;
            st = rx_par ? ST_PARITY : ST_OK;
            eng_phase = PH_IDLE;
         end
         PH_TRNW: begin
            clk = 1'b1; drv = 1'b1; dout = 1'b0;
            bit_cnt = '0; eng_phase = PH_WDATA;
         end
         PH_WDATA: begin
            clk = 1'b1; drv = 1'b1;
            dout = wr_word[bit_cnt[4:0]];
            bit_cnt = bit_cnt + 7'd1;
            if (bit_cnt >= 32) begin bit_cnt = '0; eng_phase = PH_WPAR; end
         end
         PH_WPAR: begin
            clk = 1'b1; drv = 1'b1;
            dout = ^wr_word;
            done = 1'b1; eng_phase = PH_IDLE;
         end
         PH_TRNF: begin
            clk = 1'b1;
            if (rx_ack == ACK_WAIT) begin
               retry_cnt = retry_cnt + 8'd1;
               if (retry_cnt >= retry_limit) begin
                  done = 1'b1; st = ST_TIMEOUT; eng_phase = PH_IDLE;
               end else begin
                  bit_cnt = '0; eng_phase = PH_REQ;
               end
            end else begin
               done = 1'b1;
               st = (rx_ack == ACK_FAULT) ? ST_FAULT : ST_BAD_ACK;
               eng_phase = PH_IDLE;
            end
         end
         default: begin
            drv  = line_drv;
            dout = line_drv ? line_level : 1'b0;
         end
      endcase
      if (clk) begin
         line_drv = drv;
         if (drv) line_level = dout;
      end
      if (done && eng_phase == PH_IDLE && line_drv) line_level = 1'b0;
      r.clock_active = clk;
      r.swdio_out    = dout;
      r.swdio_drive  = drv;
      r.busy_res     = (eng_phase != PH_IDLE);
      r.done_res     = done;
      r.status       = st;
      r.read_data    = rd;
      return r;
   endfunction

   // target side of the wire: ack, read data and parity, noise elsewhere
   function automatic logic target_swdio();
      logic b;
      b = 1'($urandom_range(0, 1));
      case (eng_phase)
         PH_ACK: begin
            if (bit_cnt == 0) begin
               if (ack_plan.size() != 0) cur_ack = ack_plan.pop_front();
               else cur_ack = ACK_OK;
            end
            b = cur_ack[bit_cnt[1:0]];
         end
         PH_RDATA: b = rd_plan[bit_cnt[4:0]];
         PH_RPAR:  b = (^rd_plan) ^ rd_bad_par;
         default: ;
      endcase
      return b;
   endfunction

   function automatic req_type rand_item(input logic [1:0] kind);
      req_type it;
      it.req_type       = kind;
      it.ap_not_dp      = 1'($urandom_range(0, 1));
      it.read_not_write = 1'($urandom_range(0, 1));
      it.reg_addr       = 2'($urandom_range(0, 3));
      it.write_data     = $urandom;
      it.swdio_in       = 1'b0;
      return it;
   endfunction

   function automatic logic [1:0] busy_kind();
      if ($urandom_range(0, 99) < busy_cmd_rate) return 2'($urandom_range(1, 3));
      return REQ_TICK;
   endfunction

   // one transfer on the request channel, predicted once accepted
   task automatic send_item(input req_type it);
      int n;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         n = $urandom_range(1, 7);
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      it.swdio_in = target_swdio();
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (req_stall);
      expected_cycles.push_back(engine_cycle(it));
      n_items++;
   endtask

   task automatic plan_acks(input int n_wait, input logic [2:0] last);
      ack_plan.delete();
      repeat (n_wait) ack_plan.push_back(ACK_WAIT);
      ack_plan.push_back(last);
   endtask

   task automatic plan_read(input logic [31:0] word, input logic bad);
      rd_plan    = word;
      rd_bad_par = bad;
   endtask

   // start an operation and clock it through to completion
   task automatic run_op(input logic [1:0] kind, input logic ap, input logic rnw,
                         input logic [1:0] addr, input logic [31:0] wdata);
      req_type it;
      it = rand_item(kind);
      it.ap_not_dp      = ap;
      it.read_not_write = rnw;
      it.reg_addr       = addr;
      it.write_data     = wdata;
      send_item(it);
      while (eng_phase != PH_IDLE) send_item(rand_item(busy_kind()));
   endtask

   // idle cycles, the unused request code included
   task automatic idle_ticks(input int n);
      repeat (n) send_item(rand_item($urandom_range(0, 1) ? REQ_TICK : REQ_SPARE));
   endtask

   // retry limit update over apb, only with the engine idle
   task automatic set_retry_limit(input logic [7:0] v);
      req_valid <= 1'b0;
      while (expected_cycles.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= RETRY_ADDR;
      pwdata <= {24'b0, v};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      retry_limit = v;
      // read back
      pwrite <= 1'b0; penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[7:0] !== v) begin
         $display("%0t: max_retries readback expected %h actual %h", $time, v, prdata[7:0]);
         errors++;
      end
      psel <= 1'b0; penable <= 1'b0;
   endtask

   task automatic test_line_reset;
      run_op(REQ_LINE_RESET, 1'b0, 1'b0, 2'd0, 32'h0);
      idle_ticks(4);
   endtask

   task automatic test_writes;
      plan_acks(0, ACK_OK);
      run_op(REQ_XFER, 1'b0, 1'b0, 2'd0, 32'h0000_0000);
      plan_acks(0, ACK_OK);
      run_op(REQ_XFER, 1'b1, 1'b0, 2'd3, 32'hFFFF_FFFF);
      plan_acks(0, ACK_OK);
      run_op(REQ_XFER, 1'b0, 1'b0, 2'd1, 32'hA5A5_A5A5);
      plan_acks(0, ACK_OK);
      run_op(REQ_XFER, 1'b1, 1'b0, 2'd2, 32'h5A5A_5A5B);
      idle_ticks(2);
   endtask

   task automatic test_reads;
      plan_acks(0, ACK_OK); plan_read(32'h0000_0000, 1'b0);
      run_op(REQ_XFER, 1'b0, 1'b1, 2'd0, $urandom);
      plan_acks(0, ACK_OK); plan_read(32'hFFFF_FFFF, 1'b0);
      run_op(REQ_XFER, 1'b1, 1'b1, 2'd3, $urandom);
      // wrong parity from the target
      plan_acks(0, ACK_OK); plan_read(32'h8000_0001, 1'b1);
      run_op(REQ_XFER, 1'b1, 1'b1, 2'd1, $urandom);
      plan_acks(0, ACK_OK); plan_read($urandom, 1'b1);
      run_op(REQ_XFER, 1'b0, 1'b1, 2'd2, $urandom);
   endtask

   task automatic test_bad_acks;
      plan_acks(0, ACK_FAULT);
      run_op(REQ_XFER, 1'b0, 1'b0, 2'd1, $urandom);
      plan_acks(0, 3'b000);
      run_op(REQ_XFER, 1'b1, 1'b1, 2'd2, $urandom);
      plan_acks(0, 3'b111);
      run_op(REQ_XFER, 1'b0, 1'b1, 2'd3, $urandom);
      // wait answered twice, then accepted
      plan_acks(2, ACK_OK); plan_read($urandom, 1'b0);
      run_op(REQ_XFER, 1'b1, 1'b1, 2'd0, $urandom);
      plan_acks(1, ACK_OK);
      run_op(REQ_XFER, 1'b1, 1'b0, 2'd0, $urandom);
      idle_ticks(3);
   endtask

   // commands arriving mid-operation must be dropped
   task automatic test_busy_commands;
      busy_cmd_rate = 60;
      plan_acks(0, ACK_OK); plan_read($urandom, 1'b0);
      run_op(REQ_XFER, 1'b0, 1'b1, 2'd1, $urandom);
      run_op(REQ_LINE_RESET, 1'b1, 1'b1, 2'd3, $urandom);
      busy_cmd_rate = 8;
   endtask

   task automatic test_retry_limits;
      set_retry_limit(8'd1);
      plan_acks(1, ACK_OK);
      run_op(REQ_XFER, 1'b0, 1'b1, 2'd0, $urandom);
      // zero still allows one attempt
      set_retry_limit(8'd0);
      plan_acks(1, ACK_OK);
      run_op(REQ_XFER, 1'b1, 1'b0, 2'd1, $urandom);
      set_retry_limit(8'd3);
      plan_acks(3, ACK_OK);
      run_op(REQ_XFER, 1'b0, 1'b0, 2'd2, $urandom);
      plan_acks(2, ACK_OK);
      run_op(REQ_XFER, 1'b1, 1'b0, 2'd3, $urandom);
      set_retry_limit(8'd255);
      plan_acks(4, ACK_OK); plan_read($urandom, 1'b0);
      run_op(REQ_XFER, 1'b0, 1'b1, 2'd3, $urandom);
      set_retry_limit(MAX_RETRIES_RESET);
   endtask

   task automatic test_random;
      int stop_at, n_wait, pick;
      logic [2:0] last;
      logic [31:0] wdata;
      stop_at = n_items + 880;
      while (n_items < stop_at) begin
         // quiet tail, and quiet stretches earlier on
         if (n_items > stop_at - 300) idle_on <= 1'b0;
         else if ($urandom_range(0, 9) == 0) idle_on <= ~idle_on;
         if ($urandom_range(0, 11) == 0) begin
            case ($urandom_range(0, 7))
               0: set_retry_limit(8'd0);
               1: set_retry_limit(8'd1);
               2: set_retry_limit(8'd2);
               3: set_retry_limit(8'd255);
               4: set_retry_limit(MAX_RETRIES_RESET);
               default: set_retry_limit(8'($urandom_range(1, 6)));
            endcase
         end
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            run_op(REQ_LINE_RESET, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   2'($urandom_range(0, 3)), $urandom);
         end else if (pick < 13) begin
            idle_ticks($urandom_range(1, 3));
         end else begin
            pick = $urandom_range(0, 99);
            n_wait = (pick < 20) ? $urandom_range(1, 5) : 0;
            pick = $urandom_range(0, 99);
            if (pick < 80) last = ACK_OK;
            else if (pick < 90) last = ACK_FAULT;
            else begin
               case ($urandom_range(0, 4))
                  0: last = 3'b000;
                  1: last = 3'b011;
                  2: last = 3'b101;
                  3: last = 3'b110;
                  default: last = 3'b111;
               endcase
            end
            plan_acks(n_wait, last);
            plan_read($urandom, $urandom_range(0, 9) == 0);
            case ($urandom_range(0, 5))
               0: wdata = 32'h0;
               1: wdata = 32'hFFFF_FFFF;
               default: wdata = $urandom;
            endcase
            run_op(REQ_XFER, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   2'($urandom_range(0, 3)), wdata);
         end
      end
   endtask

   // response side stall bursts
   always @(posedge clock) begin
      if (reset || !idle_on) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 9) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 6);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h actual %h", $time, name, want, got);
         errors++;
      end
   endtask

   // compare each result transfer with the oldest prediction
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_cycles.size() == 0) begin
            $display("%0t: unexpected result, expected none actual %h", $time, rsp_data);
            errors++;
         end else begin
            want = expected_cycles.pop_front();
            check_field("clock_active", 32'(want.clock_active),
                        32'(rsp_data.clock_active));
            check_field("swdio_out", 32'(want.swdio_out), 32'(rsp_data.swdio_out));
            check_field("swdio_drive", 32'(want.swdio_drive), 32'(rsp_data.swdio_drive));
            check_field("busy_res", 32'(want.busy_res), 32'(rsp_data.busy_res));
            check_field("done_res", 32'(want.done_res), 32'(rsp_data.done_res));
            check_field("status", 32'(want.status), 32'(rsp_data.status));
            check_field("read_data", want.read_data, rsp_data.read_data);
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_line_reset();
      test_writes();
      test_reads();
      test_bad_acks();
      test_busy_commands();
      test_retry_limits();
      test_random();
      req_valid <= 1'b0;
      while (expected_cycles.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (errors == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule
